>>> rtl/core/fskm_pkg.sv
package fskm_pkg;

  // Fixed field widths of the stream items and of the registers.
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned ToggleW  = 16;
  localparam int unsigned GapW     = 22;
  localparam int unsigned LenW     = 5;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  // Register reset values.
  localparam logic [PeriodW-1:0] PeriodOneRst  = 16'd499;
  localparam logic [PeriodW-1:0] PeriodZeroRst = 16'd293;
  localparam logic [ToggleW-1:0] TogglesOneRst  = 16'd100;
  localparam logic [ToggleW-1:0] TogglesZeroRst = 16'd170;
  localparam logic [GapW-1:0]    GapTicksRst    = 22'd2000000;
  localparam logic [LenW-1:0]    PacketBytesRst = 5'd9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD_ONE   = 3'd0,
    REG_PERIOD_ZERO  = 3'd1,
    REG_TOGGLES_ONE  = 3'd2,
    REG_TOGGLES_ZERO = 3'd3,
    REG_GAP_TICKS    = 3'd4,
    REG_PACKET_BYTES = 3'd5,
    REG_RUN_ENABLE   = 3'd6
  } fskm_reg_e;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } fskm_kind_e;

  typedef struct packed {
    logic [PeriodW-1:0] period_for_one;
    logic [PeriodW-1:0] period_for_zero;
    logic [ToggleW-1:0] toggles_for_one;
    logic [ToggleW-1:0] toggles_for_zero;
    logic [GapW-1:0]    gap_ticks;
    logic [LenW-1:0]    packet_bytes;
    logic               run_enable;
  } fskm_cfg_t;

  // Packed so that subcarrier lands in bit 0.
  typedef struct packed {
    logic bit_start;
    logic packet_active;
    logic bit_level;
    logic subcarrier;
  } fskm_res_t;

endpackage

>>> rtl/core/fskm_ram.sv
module fskm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read of the entry being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> rtl/core/fskm_engine.sv
module fskm_engine
  import fskm_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                wr_i,
  input  logic [IndexW-1:0]   wr_idx_i,
  input  logic [ByteW-1:0]    wr_data_i,
  input  fskm_cfg_t           cfg_i,
  output fskm_res_t           res_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = (AW + 1 > LenW) ? AW + 1 : LenW;
  localparam int unsigned XW = ((AW > IndexW) ? AW : IndexW) + 1;

  // Control state.
  logic [PeriodW-1:0] period_q, period_d;
  logic [ToggleW-1:0] toggle_q, toggle_d;
  logic [2:0]         bit_q, bit_d;
  logic [AW-1:0]      byte_q, byte_d;
  logic [GapW-1:0]    gap_q, gap_d;
  logic               in_gap_q, in_gap_d;
  logic               started_q, started_d;
  logic               wave_q, wave_d;
  logic               cur_bit_q, cur_bit_d;

  // Write forwarding over the registered read of the store.
  logic               fwd_en_q;
  logic [AW-1:0]      fwd_addr_q;
  logic [ByteW-1:0]   fwd_data_q;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ByteW-1:0]   rdata_a, rdata_b;
  logic [ByteW-1:0]   cur_byte, nxt_byte;
  logic [AW-1:0]      byte_nxt_addr;

  logic [CW-1:0]      len;
  logic [PeriodW-1:0] cur_period, adv_top;
  logic [ToggleW-1:0] need, toggle_inc;
  logic [AW:0]        byte_inc;
  logic               adv_en, wrap, bs;

  assign wr_en   = wr_i && (XW'(wr_idx_i) < XW'(STORE_DEPTH));
  assign wr_addr = AW'(wr_idx_i);

  fskm_ram #(
    .WIDTH (ByteW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data_i),
    .raddr_a_i (byte_d),
    .raddr_b_i (byte_d + AW'(1)),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign byte_nxt_addr = byte_q + AW'(1);
  assign cur_byte = (fwd_en_q && fwd_addr_q == byte_q) ? fwd_data_q : rdata_a;
  assign nxt_byte = (fwd_en_q && fwd_addr_q == byte_nxt_addr) ? fwd_data_q : rdata_b;

  always_comb begin
    len = CW'(cfg_i.packet_bytes);
    if (len == '0) begin
      len = CW'(1);
    end else if (len > CW'(STORE_DEPTH)) begin
      len = CW'(STORE_DEPTH);
    end
  end

  assign cur_period = cur_bit_q ? cfg_i.period_for_one : cfg_i.period_for_zero;

  always_comb begin
    need = cur_bit_q ? cfg_i.toggles_for_one : cfg_i.toggles_for_zero;
    if (need == '0) begin
      need = ToggleW'(1);
    end
  end

  assign toggle_inc = toggle_q + ToggleW'(1);
  assign byte_inc   = {1'b0, byte_q} + (AW + 1)'(1);

  always_comb begin
    period_d  = period_q;
    toggle_d  = toggle_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    gap_d     = gap_q;
    in_gap_d  = in_gap_q;
    started_d = started_q;
    wave_d    = wave_q;
    cur_bit_d = cur_bit_q;
    adv_en    = 1'b0;
    adv_top   = cur_period;
    bs        = 1'b0;
    wrap      = (period_q >= adv_top);

    if (tick_i) begin
      if (!started_q || (in_gap_q && gap_q >= cfg_i.gap_ticks)) begin
        if (cfg_i.run_enable) begin
          // Packet start; byte_q is zero whenever idle or in the gap.
          started_d = 1'b1;
          in_gap_d  = 1'b0;
          byte_d    = '0;
          bit_d     = 3'd7;
          toggle_d  = '0;
          period_d  = '0;
          cur_bit_d = cur_byte[7];
          bs        = 1'b1;
        end else begin
          started_d = 1'b0;
          in_gap_d  = 1'b0;
          gap_d     = '0;
          adv_en    = 1'b1;
          adv_top   = cfg_i.period_for_one;
        end
      end else if (in_gap_q) begin
        gap_d  = gap_q + GapW'(1);
        adv_en = 1'b1;
      end else begin
        adv_en = 1'b1;
        if (wrap) begin
          if (toggle_inc < need) begin
            toggle_d = toggle_inc;
          end else begin
            toggle_d = '0;
            if (bit_q != 3'd0) begin
              bit_d     = bit_q - 3'd1;
              cur_bit_d = cur_byte[bit_q - 3'd1];
              bs        = 1'b1;
            end else begin
              bit_d = 3'd7;
              if (CW'(byte_inc) >= len) begin
                byte_d   = '0;
                in_gap_d = 1'b1;
                gap_d    = '0;
              end else begin
                byte_d    = byte_inc[AW-1:0];
                cur_bit_d = nxt_byte[7];
                bs        = 1'b1;
              end
            end
          end
        end
      end
    end

    wrap = (period_q >= adv_top);
    if (adv_en) begin
      if (wrap) begin
        period_d = '0;
        wave_d   = ~wave_q;
      end else begin
        period_d = period_q + PeriodW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= '0;
      toggle_q  <= '0;
      bit_q     <= 3'd7;
      byte_q    <= '0;
      gap_q     <= '0;
      in_gap_q  <= 1'b0;
      started_q <= 1'b0;
      wave_q    <= 1'b0;
      cur_bit_q <= 1'b0;
      fwd_en_q  <= 1'b0;
    end else begin
      period_q  <= period_d;
      toggle_q  <= toggle_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      gap_q     <= gap_d;
      in_gap_q  <= in_gap_d;
      started_q <= started_d;
      wave_q    <= wave_d;
      cur_bit_q <= cur_bit_d;
      fwd_en_q  <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= wr_addr;
    fwd_data_q <= wr_data_i;
  end

  always_comb begin
    res_o.subcarrier    = wave_d;
    res_o.packet_active = started_d && !in_gap_d;
    res_o.bit_level     = started_d && !in_gap_d && cur_bit_d;
    res_o.bit_start     = bs;
  end

  a_gap_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_gap_q |-> started_q)
    else $error("gap state without a started packet");

  a_byte_zero_when_not_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_q != '0) |-> (started_q && !in_gap_q))
    else $error("byte position left nonzero outside a packet");

  a_start_restarts_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && !started_q && cfg_i.run_enable) |=>
      (started_q && !in_gap_q && period_q == '0 && toggle_q == '0 && bit_q == 3'd7))
    else $error("packet start did not restart the counters");

  a_bit_start_only_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bs |-> (tick_i && res_o.packet_active))
    else $error("bit start flagged outside an active packet");

endmodule

>>> rtl/core/fsk_subcarrier_packet_modulator_core.sv
// Binary FSK square-wave subcarrier modulator with a small packet store.
// Every input transaction is either one clock tick of the modulator
// (tuser = 0) or a write of one byte into the packet store (tuser = 1), and
// every input transaction produces exactly one output transaction carrying
// the subcarrier level, the bit being sent, the packet-active flag and a
// bit-start strobe. The block accepts one transaction per clock cycle; the
// result for a transaction appears in the output register on the following
// cycle, and the input side accepts only while that register is empty
// or draining. The packet store is a registered dual-read RAM: both the
// byte at the current position and the byte after it are read ahead every
// cycle, and a store write in the previous cycle is forwarded, so bit
// and byte changes never wait on the memory. The store has no reset and no
// clearing pass; sending an entry that was never written gives undefined
// levels. Configuration registers are written through a simple write port
// with no read-back; indexes beyond the register list are ignored.
module fsk_subcarrier_packet_modulator_core
  import fskm_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: [3:0] store_index, [11:4] store_value, [15:12] zero.
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: [0] kind.
  input  logic                s_axis_tuser,

  // Output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: [0] subcarrier, [1] bit_level, [2] packet_active, [3] bit_start,
  // [7:4] zero.
  output logic [OutDataW-1:0] m_axis_tdata,

  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  fskm_cfg_t  cfg_q;
  fskm_res_t  res;
  fskm_res_t  out_q;
  logic       out_valid_q;
  logic       in_accept;
  fskm_kind_e kind;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_for_one   <= PeriodOneRst;
      cfg_q.period_for_zero  <= PeriodZeroRst;
      cfg_q.toggles_for_one  <= TogglesOneRst;
      cfg_q.toggles_for_zero <= TogglesZeroRst;
      cfg_q.gap_ticks        <= GapTicksRst;
      cfg_q.packet_bytes     <= PacketBytesRst;
      cfg_q.run_enable       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD_ONE:   cfg_q.period_for_one   <= cfg_wdata_i[PeriodW-1:0];
        REG_PERIOD_ZERO:  cfg_q.period_for_zero  <= cfg_wdata_i[PeriodW-1:0];
        REG_TOGGLES_ONE:  cfg_q.toggles_for_one  <= cfg_wdata_i[ToggleW-1:0];
        REG_TOGGLES_ZERO: cfg_q.toggles_for_zero <= cfg_wdata_i[ToggleW-1:0];
        REG_GAP_TICKS:    cfg_q.gap_ticks        <= cfg_wdata_i[GapW-1:0];
        REG_PACKET_BYTES: cfg_q.packet_bytes     <= cfg_wdata_i[LenW-1:0];
        REG_RUN_ENABLE:   cfg_q.run_enable       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // The output register frees up whenever its contents are taken, so an
  // input transaction can enter in the same cycle the previous result leaves.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign kind          = fskm_kind_e'(s_axis_tuser);

  fskm_engine #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (in_accept && kind == KIND_TICK),
    .wr_i      (in_accept && kind == KIND_WRITE),
    .wr_idx_i  (s_axis_tdata[IndexW-1:0]),
    .wr_data_i (s_axis_tdata[IndexW+ByteW-1:IndexW]),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

endmodule
